// File: hdl/mfb_pkg.sv
package mfb_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 512;
    localparam int unsigned HDR_TRL_BYTES   = 10;
    localparam logic [15:0] LEN_MAX         = 16'(MAX_FRAME_BYTES - HDR_TRL_BYTES);
    localparam logic [15:0] MIN_PAYLOAD     = 16'd8;

    localparam logic [7:0]  PREAMBLE_1 = 8'h55;
    localparam logic [7:0]  PREAMBLE_2 = 8'hFF;
    localparam logic [7:0]  CRC8_SEED  = 8'hFF;
    localparam logic [15:0] CRC16_SEED = 16'hFFFF;

    localparam logic        MODE_HDR  = 1'b0;
    localparam logic        MODE_DATA = 1'b1;

    localparam logic [1:0]  ST_OK      = 2'd0;
    localparam logic [1:0]  ST_SHORT   = 2'd1;
    localparam logic [1:0]  ST_LARGE   = 2'd2;
    localparam logic [1:0]  ST_NOFRAME = 2'd3;

    localparam int unsigned MAX_RES = 8;
    localparam int unsigned IDX_W   = $clog2(MAX_RES);
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [CNT_W-1:0]      cnt;
    } t_batch;

    function automatic logic [7:0] crc8_step(input logic [7:0] octet, input logic [7:0] crc);
        logic [15:0] c;
        logic [15:0] acc;
        acc = '0;
        c   = {8'd0, octet ^ crc};
        for (int i = 0; i < 8; i++) begin
            acc = acc ^ (c << i);
        end
        return {acc[7:1], acc[8]};
    endfunction

    function automatic logic [15:0] crc16_step(input logic [7:0] octet, input logic [15:0] crc);
        logic [23:0] lo;
        logic [23:0] r;
        lo = {16'd0, crc[7:0] ^ octet};
        r  = {16'd0, crc[15:8]} ^ (lo << 8) ^ (lo << 3) ^ (lo << 12) ^ (lo >> 4)
           ^ (lo & 24'h00000F) ^ ((lo & 24'h00000F) << 7);
        return r[15:0];
    endfunction

endpackage

// File: hdl/mfb_encoder.sv
module mfb_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic                              i_mode,
    input  logic [7:0]                        i_ftype,
    input  logic [7:0]                        i_dest_addr,
    input  logic [7:0]                        i_src_addr,
    input  logic [15:0]                       i_payload_len,
    input  logic [7:0]                        i_data_byte,
    output mfb_pkg::t_batch                   o_batch
);

    logic        r_open;
    logic [15:0] r_left;
    logic [15:0] r_crc;
    logic        n_open;
    logic [15:0] n_left;
    logic [15:0] n_crc;

    logic [7:0]  hdr [0:4];
    logic [7:0]  hcrc [0:5];
    logic [15:0] dcrc;
    logic [15:0] fin;
    logic [15:0] left_dec;

    always_comb begin
        hdr[0] = i_ftype;
        hdr[1] = i_dest_addr;
        hdr[2] = i_src_addr;
        hdr[3] = i_payload_len[15:8];
        hdr[4] = i_payload_len[7:0];
        hcrc[0] = mfb_pkg::CRC8_SEED;
        for (int i = 0; i < 5; i++) begin
            hcrc[i+1] = mfb_pkg::crc8_step(hdr[i], hcrc[i]);
        end
        dcrc     = mfb_pkg::crc16_step(i_data_byte, r_crc);
        fin      = ~dcrc;
        left_dec = (r_left != 16'd0) ? r_left - 16'd1 : r_left;
    end

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_crc  = r_crc;
        for (int k = 0; k < mfb_pkg::MAX_RES; k++) begin
            o_batch.res[k] = '{out_byte: 8'd0, last: 1'b0, status: mfb_pkg::ST_OK};
        end
        o_batch.cnt = mfb_pkg::CNT_W'(1);
        if (i_mode == mfb_pkg::MODE_HDR) begin
            if (i_payload_len < mfb_pkg::MIN_PAYLOAD) begin
                n_open = 1'b0;
                o_batch.res[0].status = mfb_pkg::ST_SHORT;
            end else if (i_payload_len > mfb_pkg::LEN_MAX) begin
                n_open = 1'b0;
                o_batch.res[0].status = mfb_pkg::ST_LARGE;
            end else begin
                o_batch.res[0].out_byte = mfb_pkg::PREAMBLE_1;
                o_batch.res[1].out_byte = mfb_pkg::PREAMBLE_2;
                for (int k = 0; k < 5; k++) begin
                    o_batch.res[k+2].out_byte = hdr[k];
                end
                o_batch.res[7].out_byte = ~hcrc[5];
                o_batch.res[7].last     = 1'b1;
                o_batch.cnt = mfb_pkg::CNT_W'(mfb_pkg::MAX_RES);
                n_open = 1'b1;
                n_left = i_payload_len;
                n_crc  = mfb_pkg::CRC16_SEED;
            end
        end else if (!r_open) begin
            o_batch.res[0].status = mfb_pkg::ST_NOFRAME;
        end else begin
            n_crc  = dcrc;
            n_left = left_dec;
            o_batch.res[0].out_byte = i_data_byte;
            if (left_dec == 16'd0) begin
                o_batch.res[1].out_byte = fin[7:0];
                o_batch.res[2].out_byte = fin[15:8];
                o_batch.res[2].last     = 1'b1;
                o_batch.cnt = mfb_pkg::CNT_W'(3);
                n_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
            r_crc  <= mfb_pkg::CRC16_SEED;
        end else if (i_take) begin
            r_open <= n_open;
            r_left <= n_left;
            r_crc  <= n_crc;
        end
    end

endmodule

// File: hdl/mfb_serializer.sv
module mfb_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  mfb_pkg::t_batch      i_batch,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mfb_pkg::t_result     o_res
);

    mfb_pkg::t_result [mfb_pkg::MAX_RES-1:0] r_res;
    logic [mfb_pkg::CNT_W-1:0]               r_cnt;
    logic [mfb_pkg::IDX_W-1:0]               r_idx;
    logic                                    take;
    logic                                    at_end;

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && i_ready;
    assign at_end  = ((mfb_pkg::CNT_W'(r_idx) + mfb_pkg::CNT_W'(1)) == r_cnt);
    assign o_free  = !o_valid || (take && at_end);
    assign o_res   = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (take) begin
            if (at_end) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + mfb_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

endmodule

// File: hdl/mstp_frame_builder.sv
// MS/TP frame encoder with stream ports. A header beat (tuser 0) yields eight output
// beats: preamble, five header octets and the inverted header CRC-8, the last one
// marked tlast; a rejected header yields one error beat. A data beat (tuser 1) yields
// one octet, or three beats on the final byte (octet, CRC-16 low, CRC-16 high with
// tlast), or an error beat if no frame is open. Items are encoded combinationally into
// a result buffer that drains one beat per cycle while i_m_tready is high; the next
// item is taken as the buffer's last beat leaves, so payload bytes stream at one per cycle.
module mstp_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // ftype, dest_addr, src_addr, payload_len, data_byte
    input  logic [47:0] i_s_tdata,
    // mode
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_byte
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    // status
    output logic [1:0]  o_m_tuser
);

    mfb_pkg::t_batch  batch;
    mfb_pkg::t_result res;
    logic             free;
    logic             take;

    assign o_s_tready = free;
    assign take       = i_s_tvalid && free;

    mfb_encoder u_enc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_mode        (i_s_tuser),
        .i_ftype       (i_s_tdata[7:0]),
        .i_dest_addr   (i_s_tdata[15:8]),
        .i_src_addr    (i_s_tdata[23:16]),
        .i_payload_len (i_s_tdata[39:24]),
        .i_data_byte   (i_s_tdata[47:40]),
        .o_batch       (batch)
    );

    mfb_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_batch (batch),
        .o_free  (free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = res.out_byte;
    assign o_m_tlast = res.last;
    assign o_m_tuser = res.status;

endmodule

// File: test/tb_mstp_frame_builder.sv
module tb_mstp_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;

    class frame_scoreboard;
        mfb_pkg::t_result octet_q[$];
        bit               in_frame;
        logic [15:0]      octets_left;
        logic [15:0]      run_crc;
        int               mismatches;

        function new();
            in_frame    = 1'b0;
            octets_left = '0;
            run_crc     = mfb_pkg::CRC16_SEED;
            mismatches  = 0;
        endfunction

        function logic [7:0] hdr_crc_next(logic [7:0] octet, logic [7:0] crc);
            logic [15:0] x;
            logic [15:0] sum;
            x   = {8'h00, octet ^ crc};
            sum = x ^ (x << 1) ^ (x << 2) ^ (x << 3) ^ (x << 4) ^ (x << 5) ^ (x << 6)
                ^ (x << 7);
            return (sum[7:0] & 8'hFE) | {7'd0, sum[8]};
        endfunction

        function logic [15:0] data_crc_next(logic [7:0] octet, logic [15:0] crc);
            logic [31:0] x;
            logic [31:0] acc;
            x   = {24'h0, crc[7:0] ^ octet};
            acc = {16'h0, crc[15:8]} ^ (x << 8) ^ (x << 3) ^ (x << 12) ^ (x >> 4)
                ^ {28'h0, x[3:0]} ^ ({28'h0, x[3:0]} << 7);
            return acc[15:0];
        endfunction

        function void queue_octet(logic [7:0] octet, logic last, logic [1:0] status);
            mfb_pkg::t_result r;
            r.out_byte = octet;
            r.last     = last;
            r.status   = status;
            octet_q.push_back(r);
        endfunction

        function void note_beat(logic mode, logic [47:0] data);
            logic [7:0]  hdr [5];
            logic [15:0] len;
            logic [15:0] fin;
            logic [7:0]  crc8;
            logic [7:0]  db;
            len = data[39:24];
            db  = data[47:40];
            if (mode == mfb_pkg::MODE_HDR) begin
                if (len < mfb_pkg::MIN_PAYLOAD) begin
                    in_frame = 1'b0;
                    queue_octet(8'h00, 1'b0, mfb_pkg::ST_SHORT);
                end else if ({16'h0, len} + mfb_pkg::HDR_TRL_BYTES
                             > mfb_pkg::MAX_FRAME_BYTES) begin
                    in_frame = 1'b0;
                    queue_octet(8'h00, 1'b0, mfb_pkg::ST_LARGE);
                end else begin
                    hdr[0] = data[7:0];
                    hdr[1] = data[15:8];
                    hdr[2] = data[23:16];
                    hdr[3] = len[15:8];
                    hdr[4] = len[7:0];
                    crc8   = mfb_pkg::CRC8_SEED;
                    queue_octet(mfb_pkg::PREAMBLE_1, 1'b0, mfb_pkg::ST_OK);
                    queue_octet(mfb_pkg::PREAMBLE_2, 1'b0, mfb_pkg::ST_OK);
                    for (int k = 0; k < 5; k++) begin
                        crc8 = hdr_crc_next(hdr[k], crc8);
                        queue_octet(hdr[k], 1'b0, mfb_pkg::ST_OK);
                    end
                    queue_octet(~crc8, 1'b1, mfb_pkg::ST_OK);
                    in_frame    = 1'b1;
                    octets_left = len;
                    run_crc     = mfb_pkg::CRC16_SEED;
                end
            end else if (!in_frame) begin
                queue_octet(8'h00, 1'b0, mfb_pkg::ST_NOFRAME);
            end else begin
                run_crc = data_crc_next(db, run_crc);
                queue_octet(db, 1'b0, mfb_pkg::ST_OK);
                if (octets_left != 0) begin
                    octets_left = octets_left - 16'd1;
                end
                if (octets_left == 0) begin
                    fin = ~run_crc;
                    queue_octet(fin[7:0], 1'b0, mfb_pkg::ST_OK);
                    queue_octet(fin[15:8], 1'b1, mfb_pkg::ST_OK);
                    in_frame = 1'b0;
                end
            end
        endfunction

        function void check_beat(logic [7:0] octet, logic last, logic [1:0] status);
            mfb_pkg::t_result want;
            bit               bad;
            if (octet_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected output beat: octet %02h last %0b status %0d",
                             octet, last, status);
                end
            end else begin
                want = octet_q.pop_front();
                bad  = (want.out_byte !== octet) || (want.last !== last)
                    || (want.status !== status);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("output mismatch: exp octet %02h last %0b status %0d,",
                                 want.out_byte, want.last, want.status,
                                 " got octet %02h last %0b status %0d",
                                 octet, last, status);
                    end
                end
            end
        endfunction

        function int pending();
            return octet_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic [1:0]  o_m_tuser;

    frame_scoreboard sb;
    bit          tail_phase;
    bit          rx_hold_req;
    int unsigned n_sent;
    int unsigned idle_cycles;

    mstp_frame_builder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // accepted beats on both sides, sampled at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_beat(i_s_tuser, i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_beat(o_m_tdata, o_m_tlast, o_m_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side backpressure
    initial begin
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic mode, input logic [47:0] data);
        if (!tail_phase && $urandom_range(0, 6) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [7:0] dst,
                               input logic [7:0] src, input logic [15:0] len);
        send_beat(mfb_pkg::MODE_HDR, {8'($urandom), len, src, dst, ftype});
    endtask

    task automatic send_octet(input logic [7:0] octet);
        send_beat(mfb_pkg::MODE_DATA, {octet, 40'({$urandom, $urandom})});
    endtask

    task automatic send_frame(input int unsigned len, input int unsigned count);
        send_header(8'($urandom), 8'($urandom), 8'($urandom), 16'(len));
        repeat (count) send_octet(8'($urandom));
    endtask

    initial begin
        int unsigned pick;
        int unsigned len;
        bit          held;
        bit          paused;
        sb          = new();
        tail_phase  = 1'b0;
        rx_hold_req = 1'b0;
        n_sent      = 0;
        held        = 1'b0;
        paused      = 1'b0;
        idle_cycles <= 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= mfb_pkg::MODE_HDR;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: errors, size limits, abandoned and complete frames
        send_octet(8'hA5);
        send_header(8'h01, 8'h02, 8'h03, 16'd0);
        send_header(8'h01, 8'h02, 8'h03, 16'd7);
        send_header(8'h01, 8'h02, 8'h03,
                    16'(mfb_pkg::MAX_FRAME_BYTES - mfb_pkg::HDR_TRL_BYTES + 1));
        send_header(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_header(8'hFF, 8'hFF, 8'hFF,
                    16'(mfb_pkg::MAX_FRAME_BYTES - mfb_pkg::HDR_TRL_BYTES));
        send_octet(8'h12);
        send_octet(8'h34);
        send_header(8'h00, 8'h00, 8'h00, 16'd8);
        send_octet(8'h00);
        send_octet(8'hFF);
        send_octet(8'h80);
        send_octet(8'h01);
        send_octet(8'h55);
        send_octet(8'hAA);
        send_octet(8'h0F);
        send_octet(8'hF0);
        send_octet(8'h3C);
        send_header(8'h06, 8'h7F, 8'h80, 16'd9);
        send_octet(8'h42);
        send_header(8'h06, 8'h7F, 8'h80, 16'd3);
        send_octet(8'hC3);

        // random: mostly complete frames, some truncated ones and noise
        while (n_sent < 140) begin
            if (n_sent >= 115) begin
                tail_phase = 1'b1;
            end
            if (!held && n_sent >= 60) begin
                held        = 1'b1;
                rx_hold_req = 1'b1;
                send_frame(24, 24);
            end else if (!paused && n_sent >= 95) begin
                paused = 1'b1;
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                      : $urandom_range(8, 16);
                    send_frame(len, len);
                end else if (pick < 80) begin
                    len = $urandom_range(8, 16);
                    send_frame(len, $urandom_range(0, len - 1));
                end else if (pick < 90) begin
                    send_header(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
                end else begin
                    repeat ($urandom_range(1, 3)) send_octet(8'($urandom));
                end
            end
        end
        i_s_tvalid <= 1'b0;

        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/mfb_pkg.sv
hdl/mfb_encoder.sv
hdl/mfb_serializer.sv
hdl/mstp_frame_builder.sv
test/tb_mstp_frame_builder.sv
